// ----- sv/pvmo_pkg.sv -----
// ----------------------------------------------------------------------------
// pvmo_pkg
// Shared types, codes and the arctangent table for the marker orientation unit.
// ----------------------------------------------------------------------------
package pvmo_pkg;

	// vector widths inside the cordic
	localparam int XW = 43;
	localparam int ZW = 27;
	localparam int TAB_LEN = 24;

	// 180 degrees in 1/65536 degree
	localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;
	localparam logic signed [16:0] ANGLE_MAX = 17'sd46080;

	// element commands
	typedef enum logic [2:0] {
		CMD_MOVE  = 3'd0,
		CMD_LINE  = 3'd1,
		CMD_QUAD  = 3'd2,
		CMD_CUBIC = 3'd3,
		CMD_CLOSE = 3'd4,
		CMD_END   = 3'd5
	} cmd_t;

	// marker kinds
	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_MID   = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [1:0] REG_START_EN = 2'd0;
	localparam logic [1:0] REG_MID_EN   = 2'd1;
	localparam logic [1:0] REG_END_EN   = 2'd2;

	// control sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_RUN,
		ST_HOLD
	} state_t;

	// one cordic vector with its angle accumulator
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cvec_t;

	// atan(2^-i) in 1/65536 degree
	localparam logic signed [ZW-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
		27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
		27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
		27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
		27'sd917,     27'sd458,     27'sd229,    27'sd115,
		27'sd57,      27'sd29,      27'sd14,     27'sd7,
		27'sd4,       27'sd2,       27'sd1,      27'sd0
	};

	// one vectoring rotation, driving y towards zero
	function automatic cvec_t cordic_step(input cvec_t v, input int idx);
		cvec_t r;
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		xs = v.x >>> idx;
		ys = v.y >>> idx;
		if (v.y >= 0) begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + ATAN_TAB[idx];
		end else begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - ATAN_TAB[idx];
		end
		return r;
	endfunction

endpackage

// ----- sv/pvmo_if.sv -----
// ----------------------------------------------------------------------------
// pvmo channel interfaces
// Valid/ready channels for path elements and for marker results.
// ----------------------------------------------------------------------------
interface pvmo_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        command;
	logic signed [31:0] pa_x;
	logic signed [31:0] pa_y;
	logic signed [31:0] pb_x;
	logic signed [31:0] pb_y;
	logic signed [31:0] pc_x;
	logic signed [31:0] pc_y;

	modport source (output valid, command, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y,
		input ready);
	modport sink (input valid, command, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y,
		output ready);
endinterface

interface pvmo_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         marker_kind;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [16:0] angle;

	modport source (output valid, marker_kind, pos_x, pos_y, angle, input ready);
	modport sink (input valid, marker_kind, pos_x, pos_y, angle, output ready);
endinterface

// ----- sv/pvmo_norm.sv -----
// ----------------------------------------------------------------------------
// pvmo_norm
// Folds a difference vector into the right half plane and scales it up
// until its larger component reaches 2^39, eight or one bit per cycle.
// ----------------------------------------------------------------------------
module pvmo_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] dx,
	input  logic signed [32:0] dy,
	output logic               busy,
	output logic               zero,
	output pvmo_pkg::cvec_t    vec
);

	logic                           busy_q;
	logic                           zero_q;
	logic signed [pvmo_pkg::XW-1:0] x_q;
	logic signed [pvmo_pkg::XW-1:0] y_q;
	logic signed [pvmo_pkg::ZW-1:0] z_q;
	logic signed [pvmo_pkg::XW-1:0] dx_w;
	logic signed [pvmo_pkg::XW-1:0] dy_w;
	logic [pvmo_pkg::XW-1:0]        ax;
	logic [pvmo_pkg::XW-1:0]        ay;
	logic                           big;
	logic                           tiny;

	assign dx_w = pvmo_pkg::XW'(dx);
	assign dy_w = pvmo_pkg::XW'(dy);

	// magnitude tests on the stored vector
	always_comb begin
		ax   = (x_q < 0) ? pvmo_pkg::XW'(-x_q) : pvmo_pkg::XW'(x_q);
		ay   = (y_q < 0) ? pvmo_pkg::XW'(-y_q) : pvmo_pkg::XW'(y_q);
		big  = (ax[pvmo_pkg::XW-1:39] != '0) || (ay[pvmo_pkg::XW-1:39] != '0);
		tiny = (ax[pvmo_pkg::XW-1:31] == '0) && (ay[pvmo_pkg::XW-1:31] == '0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			zero_q <= 1'b0;
		end else if (start) begin
			zero_q <= (dx == 0) && (dy == 0);
			busy_q <= !((dx == 0) && (dy == 0));
		end else if (busy_q && big) begin
			busy_q <= 1'b0;
		end
	end

	// vector and starting angle
	always_ff @(posedge clk) begin
		if (start) begin
			if (dx < 0) begin
				x_q <= -dx_w;
				y_q <= -dy_w;
				z_q <= (dy >= 0) ? pvmo_pkg::DEG180 : -pvmo_pkg::DEG180;
			end else begin
				x_q <= dx_w;
				y_q <= dy_w;
				z_q <= '0;
			end
		end else if (busy_q && !big) begin
			if (tiny) begin
				x_q <= x_q <<< 8;
				y_q <= y_q <<< 8;
			end else begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end
		end
	end

	assign busy  = busy_q;
	assign zero  = zero_q;
	assign vec.x = x_q;
	assign vec.y = y_q;
	assign vec.z = z_q;

endmodule

// ----- sv/pvmo_cell.sv -----
// ----------------------------------------------------------------------------
// pvmo_cell
// One cordic iteration for the incoming and outgoing tangent vectors,
// registered and handed to the next cell.
// ----------------------------------------------------------------------------
module pvmo_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_in,
	input  pvmo_pkg::cvec_t vi_in,
	input  pvmo_pkg::cvec_t vo_in,
	output logic            vld_out,
	output pvmo_pkg::cvec_t vi_out,
	output pvmo_pkg::cvec_t vo_out
);

	logic            vld_q;
	pvmo_pkg::cvec_t vi_q;
	pvmo_pkg::cvec_t vo_q;

	// beat marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	// both lanes rotate together
	always_ff @(posedge clk) begin
		vi_q <= pvmo_pkg::cordic_step(vi_in, IDX);
		vo_q <= pvmo_pkg::cordic_step(vo_in, IDX);
	end

	assign vld_out = vld_q;
	assign vi_out  = vi_q;
	assign vo_out  = vo_q;

endmodule

// ----- sv/path_vertex_marker_orientation_unit.sv -----
// ----------------------------------------------------------------------------
// path_vertex_marker_orientation_unit
// Tracks path elements and reports start, mid and end markers with angles.
// ----------------------------------------------------------------------------
// Path elements arrive on in_ch, one beat per element; marker results leave
// on out_ch, at most one beat per element. Three enable registers are set
// through cfg_we / cfg_index / cfg_data; the user must do so only while
// the unit is idle, which the unit itself does not enforce. The path state
// is updated in the cycle an element is taken. An element that reports
// nothing frees the input again in the next cycle. One that reports a
// marker runs both tangent vectors through the normaliser (eight or one
// bit of shift per cycle) and then through a row of CORDIC_STEPS rotation
// cells. One element is in flight at a time. The result sits in an output
// register; while it is stalled the unit still takes the next element and
// works on it, and only waits when a second result is ready before the
// first has left.
// Reset clears the path state, the enables and the output valid flag.
// ----------------------------------------------------------------------------
module path_vertex_marker_orientation_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	pvmo_in_if.sink    in_ch,
	pvmo_out_if.source out_ch
);

	// configuration
	logic start_en_q;
	logic mid_en_q;
	logic end_en_q;

	// path state
	logic [1:0]         count_q;
	pvmo_pkg::kind_t    kind_q;
	logic signed [31:0] cur_x_q;
	logic signed [31:0] cur_y_q;
	logic signed [31:0] sub_x_q;
	logic signed [31:0] sub_y_q;
	logic signed [31:0] from_x_q;
	logic signed [31:0] from_y_q;
	logic signed [31:0] to_x_q;
	logic signed [31:0] to_y_q;

	// job held while the cordic runs
	pvmo_pkg::kind_t    job_kind_q;
	logic signed [31:0] job_x_q;
	logic signed [31:0] job_y_q;

	// result waiting for the output register
	pvmo_pkg::kind_t    hold_kind_q;
	logic signed [31:0] hold_x_q;
	logic signed [31:0] hold_y_q;
	logic signed [16:0] hold_ang_q;

	// output register
	logic               out_valid_q;
	pvmo_pkg::kind_t    out_kind_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic signed [16:0] out_ang_q;

	pvmo_pkg::state_t state_q;
	pvmo_pkg::state_t state_nx;

	logic            accept;
	logic            valid_cmd;
	logic            emit;
	logic            in_rdy;
	logic            inject;
	logic            hold_load;
	logic            out_load;
	logic            busy_i;
	logic            busy_o;
	logic            zero_i;
	logic            zero_o;
	logic signed [32:0] vo_dx;
	logic signed [32:0] vo_dy;
	logic signed [32:0] vi_dx;
	logic signed [32:0] vi_dy;
	pvmo_pkg::cvec_t nvi;
	pvmo_pkg::cvec_t nvo;

	logic            vld [0:CORDIC_STEPS];
	pvmo_pkg::cvec_t vi  [0:CORDIC_STEPS];
	pvmo_pkg::cvec_t vo  [0:CORDIC_STEPS];

	logic signed [pvmo_pkg::ZW:0] zi_f;
	logic signed [pvmo_pkg::ZW:0] zo_f;
	logic signed [pvmo_pkg::ZW:0] rnd;
	logic signed [16:0]          ang;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_en_q <= 1'b0;
			mid_en_q   <= 1'b0;
			end_en_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pvmo_pkg::REG_START_EN: start_en_q <= cfg_data;
				pvmo_pkg::REG_MID_EN:   mid_en_q   <= cfg_data;
				pvmo_pkg::REG_END_EN:   end_en_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// element decode
	always_comb begin
		accept    = in_ch.valid && in_rdy;
		valid_cmd = (in_ch.command <= pvmo_pkg::CMD_END);
		if (in_ch.command == pvmo_pkg::CMD_END) begin
			emit = end_en_q;
		end else if (count_q != 2'd0) begin
			emit = (kind_q == pvmo_pkg::KIND_START) ? start_en_q : mid_en_q;
		end else begin
			emit = 1'b0;
		end
		emit  = emit && valid_cmd;
		vo_dx = 33'(in_ch.pa_x) - 33'(cur_x_q);
		vo_dy = 33'(in_ch.pa_y) - 33'(cur_y_q);
		vi_dx = 33'(to_x_q) - 33'(from_x_q);
		vi_dy = 33'(to_y_q) - 33'(from_y_q);
	end

	// path state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			kind_q   <= pvmo_pkg::KIND_START;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			sub_x_q  <= '0;
			sub_y_q  <= '0;
			from_x_q <= '0;
			from_y_q <= '0;
			to_x_q   <= '0;
			to_y_q   <= '0;
		end else if (accept && valid_cmd) begin
			if (in_ch.command == pvmo_pkg::CMD_END) begin
				count_q  <= 2'd0;
				kind_q   <= pvmo_pkg::KIND_START;
				cur_x_q  <= '0;
				cur_y_q  <= '0;
				sub_x_q  <= '0;
				sub_y_q  <= '0;
				from_x_q <= '0;
				from_y_q <= '0;
				to_x_q   <= '0;
				to_y_q   <= '0;
			end else begin
				if (count_q == 2'd1) begin
					kind_q <= pvmo_pkg::KIND_MID;
				end
				if (count_q != 2'd2) begin
					count_q <= count_q + 2'd1;
				end
				unique case (in_ch.command)
					pvmo_pkg::CMD_MOVE: begin
						sub_x_q  <= in_ch.pa_x;
						sub_y_q  <= in_ch.pa_y;
						from_x_q <= cur_x_q;
						from_y_q <= cur_y_q;
						to_x_q   <= in_ch.pa_x;
						to_y_q   <= in_ch.pa_y;
						cur_x_q  <= in_ch.pa_x;
						cur_y_q  <= in_ch.pa_y;
					end
					pvmo_pkg::CMD_LINE: begin
						from_x_q <= cur_x_q;
						from_y_q <= cur_y_q;
						to_x_q   <= in_ch.pa_x;
						to_y_q   <= in_ch.pa_y;
						cur_x_q  <= in_ch.pa_x;
						cur_y_q  <= in_ch.pa_y;
					end
					pvmo_pkg::CMD_QUAD: begin
						from_x_q <= in_ch.pa_x;
						from_y_q <= in_ch.pa_y;
						to_x_q   <= in_ch.pb_x;
						to_y_q   <= in_ch.pb_y;
						cur_x_q  <= in_ch.pb_x;
						cur_y_q  <= in_ch.pb_y;
					end
					pvmo_pkg::CMD_CUBIC: begin
						from_x_q <= in_ch.pb_x;
						from_y_q <= in_ch.pb_y;
						to_x_q   <= in_ch.pc_x;
						to_y_q   <= in_ch.pc_y;
						cur_x_q  <= in_ch.pc_x;
						cur_y_q  <= in_ch.pc_y;
					end
					default: begin
						from_x_q <= cur_x_q;
						from_y_q <= cur_y_q;
						to_x_q   <= in_ch.pa_x;
						to_y_q   <= in_ch.pa_y;
						cur_x_q  <= sub_x_q;
						cur_y_q  <= sub_y_q;
						sub_x_q  <= '0;
						sub_y_q  <= '0;
					end
				endcase
			end
		end
	end

	// marker kind and position of the job
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			job_kind_q <= (in_ch.command == pvmo_pkg::CMD_END) ? pvmo_pkg::KIND_END
				: kind_q;
			job_x_q    <= cur_x_q;
			job_y_q    <= cur_y_q;
		end
	end

	// normalisers for incoming and outgoing tangents
	pvmo_norm u_norm_i (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && emit),
		.dx     (vi_dx),
		.dy     (vi_dy),
		.busy   (busy_i),
		.zero   (zero_i),
		.vec    (nvi)
	);

	pvmo_norm u_norm_o (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && emit),
		.dx     (vo_dx),
		.dy     (vo_dy),
		.busy   (busy_o),
		.zero   (zero_o),
		.vec    (nvo)
	);

	// row of rotation cells
	assign vld[0] = inject;
	assign vi[0]  = nvi;
	assign vo[0]  = nvo;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		pvmo_cell #(
			.IDX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld[g]),
			.vi_in   (vi[g]),
			.vo_in   (vo[g]),
			.vld_out (vld[g+1]),
			.vi_out  (vi[g+1]),
			.vo_out  (vo[g+1])
		);
	end

	// rounding and clamping of the final angle
	always_comb begin
		zi_f = zero_i ? '0 : (pvmo_pkg::ZW+1)'(vi[CORDIC_STEPS].z);
		zo_f = zero_o ? '0 : (pvmo_pkg::ZW+1)'(vo[CORDIC_STEPS].z);
		unique case (job_kind_q)
			pvmo_pkg::KIND_START: rnd = (zo_f + 28'sd128) >>> 8;
			pvmo_pkg::KIND_MID:   rnd = (zi_f + zo_f + 28'sd256) >>> 9;
			default:              rnd = (zi_f + 28'sd128) >>> 8;
		endcase
		if (rnd > 28'(pvmo_pkg::ANGLE_MAX)) begin
			ang = pvmo_pkg::ANGLE_MAX;
		end else if (rnd < -28'(pvmo_pkg::ANGLE_MAX)) begin
			ang = -pvmo_pkg::ANGLE_MAX;
		end else begin
			ang = rnd[16:0];
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvmo_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pvmo_pkg::ST_IDLE: if (accept && emit) state_nx = pvmo_pkg::ST_NORM;
			pvmo_pkg::ST_NORM: if (!busy_i && !busy_o) state_nx = pvmo_pkg::ST_RUN;
			pvmo_pkg::ST_RUN:  if (vld[CORDIC_STEPS]) state_nx = pvmo_pkg::ST_HOLD;
			pvmo_pkg::ST_HOLD: if (out_load) state_nx = pvmo_pkg::ST_IDLE;
			default:           state_nx = pvmo_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_rdy    = (state_q == pvmo_pkg::ST_IDLE);
		inject    = (state_q == pvmo_pkg::ST_NORM) && !busy_i && !busy_o;
		hold_load = (state_q == pvmo_pkg::ST_RUN) && vld[CORDIC_STEPS];
		out_load  = (state_q == pvmo_pkg::ST_HOLD) && (!out_valid_q || out_ch.ready);
	end

	// finished result
	always_ff @(posedge clk) begin
		if (hold_load) begin
			hold_kind_q <= job_kind_q;
			hold_x_q    <= job_x_q;
			hold_y_q    <= job_y_q;
			hold_ang_q  <= ang;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= hold_kind_q;
			out_x_q    <= hold_x_q;
			out_y_q    <= hold_y_q;
			out_ang_q  <= hold_ang_q;
		end
	end

	assign in_ch.ready        = in_rdy;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.marker_kind = out_kind_q;
	assign out_ch.pos_x       = out_x_q;
	assign out_ch.pos_y       = out_y_q;
	assign out_ch.angle       = out_ang_q;

endmodule

// ----- sv/pvmo_checker.sv -----
// ----------------------------------------------------------------------------
// pvmo_checker
// Port level checks on the marker orientation unit.
// ----------------------------------------------------------------------------
module pvmo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         out_kind,
	input logic signed [16:0] out_angle
);

	// a stalled beat keeps its kind and angle
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_kind))
		else $error("result beat changed while stalled");

	// reported angles stay inside plus or minus 180 degrees
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_angle <= 17'sd46080) && (out_angle >= -17'sd46080))
		else $error("angle out of range");

	// a result never appears in the cycle right after an element is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result too early after element");

endmodule

bind path_vertex_marker_orientation_unit pvmo_checker u_pvmo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_kind  (out_ch.marker_kind),
	.out_angle (out_ch.angle)
);
